// File: sv/qrs_pkg.sv
// Shared types and constants of the QR module pixel scaler.
package qrs_pkg;

  localparam int CFG_W      = 8;
  localparam int PIX_W      = 16;
  localparam int DIV_CNT_W  = $clog2(PIX_W);
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] MAX_SCALE_VALUE = 8'd100;
  localparam logic [CFG_W-1:0] MAX_QUIET_VALUE = 8'd100;

  localparam logic [CFG_W-1:0] SCALE_RESET = 8'd4;
  localparam logic [CFG_W-1:0] QUIET_RESET = 8'd4;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 8'd21;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_QUIET = 2'd1,
    REG_WIDTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SCALE = 2'd1,
    STATUS_BAD_QUIET = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_PIXEL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] scale;
    logic [CFG_W-1:0] quiet_zone;
    logic [CFG_W-1:0] symbol_width;
  } cfg_t;

endpackage

// File: sv/qrs_div.sv
// Restoring divider, one quotient bit per cycle.
module qrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [qrs_pkg::PIX_W-1:0]     dividend,
  input  logic [qrs_pkg::CFG_W-1:0]     divisor,
  output logic                          done,
  output logic [qrs_pkg::PIX_W-1:0]     quotient,
  output logic [qrs_pkg::CFG_W-1:0]     remainder
);

  localparam logic [qrs_pkg::DIV_CNT_W-1:0] LAST_STEP = qrs_pkg::DIV_CNT_W'(qrs_pkg::PIX_W - 1);

  logic                            active;
  logic [qrs_pkg::DIV_CNT_W-1:0]   cnt;
  logic [qrs_pkg::PIX_W-1:0]       dq;
  logic [qrs_pkg::CFG_W-1:0]       rem;
  logic [qrs_pkg::CFG_W:0]         trial;
  logic                            qbit;
  logic [qrs_pkg::CFG_W-1:0]       rem_next;

  always_comb begin
    trial = {rem, dq[qrs_pkg::PIX_W-1]};
    qbit  = (trial >= {1'b0, divisor});
    if (qbit) begin
      rem_next = qrs_pkg::CFG_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[qrs_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (active) begin
      dq  <= {dq[qrs_pkg::PIX_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

// File: sv/qrs_store.sv
// Module matrix store: one bit per module, one write and one registered read port.
module qrs_store #(
  parameter int DEPTH  = 31329,
  parameter int ADDR_W = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/qrs_regs.sv
// APB configuration registers: scale, quiet zone and symbol width.
module qrs_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output qrs_pkg::cfg_t                   cfg
);

  logic                   wr_en;
  logic [1:0]             reg_sel;
  logic [qrs_pkg::CFG_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale        <= qrs_pkg::SCALE_RESET;
      cfg.quiet_zone   <= qrs_pkg::QUIET_RESET;
      cfg.symbol_width <= qrs_pkg::WIDTH_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        qrs_pkg::REG_SCALE: cfg.scale        <= pwdata[qrs_pkg::CFG_W-1:0];
        qrs_pkg::REG_QUIET: cfg.quiet_zone   <= pwdata[qrs_pkg::CFG_W-1:0];
        qrs_pkg::REG_WIDTH: cfg.symbol_width <= pwdata[qrs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      qrs_pkg::REG_SCALE: rd_val = cfg.scale;
      qrs_pkg::REG_QUIET: rd_val = cfg.quiet_zone;
      qrs_pkg::REG_WIDTH: rd_val = cfg.symbol_width;
      default:            rd_val = '0;
    endcase
  end

  assign prdata = {{(qrs_pkg::APB_DATA_W - qrs_pkg::CFG_W){1'b0}}, rd_val};

endmodule

// File: sv/qr_module_pixel_scaler.sv
// Top level: command sequencer, module store, divider and configuration port.
//
//   channel   signals                                         direction
//   config    psel penable pwrite paddr pwdata prdata pready  APB slave
//   command   start busy cmd module_col module_row             in, busy out
//             module_dark pixel_row byte_index
//   result    done pixel_byte status                          out, one cycle
//
// A write command stores the module bit at the accepting edge; the result
// follows in the next cycle. A read passes through a check state, two serial
// divisions of 16 steps each (pixel row, then first pixel column), eight
// module lookups through the registered store read port, a drain state and
// the result state. A bad scale or quiet zone ends a read right after the
// check state. busy is low only when idle.
// Reset clears the configuration registers to their defaults; the store
// contents stay undefined until written.
module qr_module_pixel_scaler #(
  parameter int MAX_SYMBOL_WIDTH = 177
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd,
  input  logic [7:0]                      module_col,
  input  logic [7:0]                      module_row,
  input  logic                            module_dark,
  input  logic [15:0]                     pixel_row,
  input  logic [12:0]                     byte_index,
  output logic                            done,
  output logic [7:0]                      pixel_byte,
  output logic [1:0]                      status
);

  localparam int DEPTH  = MAX_SYMBOL_WIDTH * MAX_SYMBOL_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [7:0]        MAX_W8 = 8'(MAX_SYMBOL_WIDTH);
  localparam logic [ADDR_W-1:0] MAX_WA = ADDR_W'(MAX_SYMBOL_WIDTH);
  localparam int SIDE_W = 18;

  qrs_pkg::cfg_t   cfg;
  qrs_pkg::state_t state, state_next;
  qrs_pkg::status_t status_q;

  logic              accept;
  logic              cfg_bad_scale;
  logic              cfg_bad_quiet;
  logic [7:0]        eff_w;
  logic [15:0]       zone_lo;
  logic [15:0]       zone_hi;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_rdata;

  logic              div_start;
  logic [15:0]       div_dividend;
  logic              div_done;
  logic [15:0]       div_quot;
  logic [7:0]        div_rem;

  logic [15:0]       prow;
  logic [12:0]       bidx;
  logic [SIDE_W-1:0] side;
  logic              row_ok;
  logic [7:0]        my;
  logic [ADDR_W-1:0] base;
  logic [15:0]       q;
  logic [7:0]        r;
  logic [15:0]       px;
  logic [2:0]        pix_cnt;
  logic              pend;
  logic              pend_hit;
  logic [7:0]        acc;
  logic              hit;
  logic [7:0]        mx;

  qrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.scale),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  qrs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (module_dark),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept        = start & ~busy;
  assign cfg_bad_scale = (cfg.scale == '0) || (cfg.scale > qrs_pkg::MAX_SCALE_VALUE);
  assign cfg_bad_quiet = (cfg.quiet_zone > qrs_pkg::MAX_QUIET_VALUE);
  assign eff_w   = (cfg.symbol_width > MAX_W8) ? MAX_W8 : cfg.symbol_width;
  assign zone_lo = {8'd0, cfg.quiet_zone};
  assign zone_hi = 16'(cfg.quiet_zone) + 16'(eff_w);

  // Store writes happen at the accepting edge; out-of-range writes are dropped.
  assign mem_we    = accept && (cmd == qrs_pkg::CMD_WRITE) &&
                     (module_col < MAX_W8) && (module_row < MAX_W8);
  assign mem_waddr = ADDR_W'(ADDR_W'(module_row) * MAX_WA) + ADDR_W'(module_col);

  assign hit       = row_ok && ({2'b00, px} < side) && (q >= zone_lo) && (q < zone_hi);
  assign mx        = 8'(q - zone_lo);
  assign mem_raddr = base + ADDR_W'(mx);

  always_comb begin
    state_next = state;
    unique case (state)
      qrs_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (cmd == qrs_pkg::CMD_READ) ? qrs_pkg::ST_CHECK : qrs_pkg::ST_FINISH;
        end
      end
      qrs_pkg::ST_CHECK: begin
        if (cfg_bad_scale || cfg_bad_quiet) begin
          state_next = qrs_pkg::ST_FINISH;
        end else begin
          state_next = qrs_pkg::ST_DIV_ROW;
        end
      end
      qrs_pkg::ST_DIV_ROW: begin
        if (div_done) state_next = qrs_pkg::ST_DIV_COL;
      end
      qrs_pkg::ST_DIV_COL: begin
        if (div_done) state_next = qrs_pkg::ST_PIXEL;
      end
      qrs_pkg::ST_PIXEL: begin
        if (pix_cnt == 3'd7) state_next = qrs_pkg::ST_DRAIN;
      end
      qrs_pkg::ST_DRAIN:  state_next = qrs_pkg::ST_FINISH;
      qrs_pkg::ST_FINISH: state_next = qrs_pkg::ST_IDLE;
      default:            state_next = qrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != qrs_pkg::ST_IDLE);
    done         = (state == qrs_pkg::ST_FINISH);
    div_start    = 1'b0;
    div_dividend = prow;
    unique case (state)
      qrs_pkg::ST_CHECK: begin
        div_start = ~(cfg_bad_scale | cfg_bad_quiet);
      end
      qrs_pkg::ST_DIV_ROW: begin
        div_start    = div_done;
        div_dividend = {bidx, 3'b000};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qrs_pkg::ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == qrs_pkg::ST_PIXEL) begin
        pend <= 1'b1;
      end else if (state == qrs_pkg::ST_DRAIN) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prow     <= pixel_row;
      bidx     <= byte_index;
      acc      <= '0;
      status_q <= qrs_pkg::STATUS_OK;
    end
    unique case (state)
      qrs_pkg::ST_CHECK: begin
        side <= (SIDE_W'(eff_w) + SIDE_W'({cfg.quiet_zone, 1'b0})) * SIDE_W'(cfg.scale);
        if (cfg_bad_scale) begin
          status_q <= qrs_pkg::STATUS_BAD_SCALE;
        end else if (cfg_bad_quiet) begin
          status_q <= qrs_pkg::STATUS_BAD_QUIET;
        end
      end
      qrs_pkg::ST_DIV_ROW: begin
        if (div_done) begin
          row_ok <= ({2'b00, prow} < side) && (div_quot >= zone_lo) && (div_quot < zone_hi);
          my     <= 8'(div_quot - zone_lo);
        end
      end
      qrs_pkg::ST_DIV_COL: begin
        base <= ADDR_W'(ADDR_W'(my) * MAX_WA);
        if (div_done) begin
          q       <= div_quot;
          r       <= div_rem;
          px      <= {bidx, 3'b000};
          pix_cnt <= '0;
        end
      end
      qrs_pkg::ST_PIXEL: begin
        pend_hit <= hit;
        pix_cnt  <= pix_cnt + 1'b1;
        px       <= px + 1'b1;
        // advance the column position by one pixel without dividing again
        if (r + 1'b1 == cfg.scale) begin
          r <= '0;
          q <= q + 1'b1;
        end else begin
          r <= r + 1'b1;
        end
      end
      default: ;
    endcase
    if (pend) begin
      acc <= {acc[6:0], pend_hit & mem_rdata};
    end
  end

  assign pixel_byte = acc;
  assign status     = status_q;

endmodule
